### src/esc_pkg.sv
// Shared constants and helper functions for the epoch-seconds to calendar converter.
// Used by epoch_seconds_to_calendar_top; depends on nothing else.
package esc_pkg;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [11:0] NO_LEAP_CENTURY = 12'd2100;
    localparam logic [15:0] DAYS_COMMON     = 16'd365;
    localparam logic [15:0] DAYS_LEAP       = 16'd366;
    localparam logic [5:0]  SEC_PER_MIN     = 6'd60;
    localparam logic [5:0]  HOUR_PER_DAY    = 6'd24;
    localparam logic [3:0]  LAST_MONTH      = 4'd11;

    // Reciprocals for the constant divisions. Dividing by 60 takes the product
    // from bit 37 up; dividing by 24 uses one third and takes it from bit 36 up.
    // Both are exact for every 32-bit dividend.
    localparam logic [31:0] RECIP_SIXTY     = 32'h8888_8889;
    localparam logic [31:0] RECIP_THREE     = 32'hAAAA_AAAB;

    // Divider passes, one per constant division
    localparam logic [1:0] PASS_SEC  = 2'd0;
    localparam logic [1:0] PASS_MIN  = 2'd1;
    localparam logic [1:0] PASS_HOUR = 2'd2;

    // Leap rule over 1970..2106: within that span the only century years are
    // 2000, which is a multiple of 400, and 2100, which is not.
    function automatic logic is_leap(input logic [11:0] y);
        is_leap = (y[1:0] == 2'b00) && (y != NO_LEAP_CENTURY);
    endfunction

    // Length of a month, zero-based month index.
    function automatic logic [15:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        month_days = {11'd0, len};
    endfunction

endpackage

### src/epoch_seconds_to_calendar_top.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into date and time of day.
// Depends on esc_pkg for calendar constants and the leap and month-length functions.
//
// Usage:
//   Input channel: epoch_seconds with in_valid / in_ready. A transfer takes place
//   when both are high. in_ready is high only while the converter is idle.
//   Output channel: second, minute, hour, day, month, year with out_valid /
//   out_ready, held in an output register until the transfer completes.
//   Sequence: a conversion runs the three constant divisions (by 60, 60 and 24)
//   on one shared reciprocal multiplier, each registering the product first.
//   The year and month walks then share a 17-bit compare-and-subtract unit, one
//   year or one month per cycle; they remove the whole years after 1970 (0..136)
//   and then the whole months walked (0..11), and the result is loaded into the
//   output register.
//   Throughput: one item per conversion; a new item is accepted as soon as the
//   previous result sits in the output register, even if the receiver stalls.
//   If the receiver still holds the previous result when a new one is finished,
//   the converter waits until that result has been transferred.
//   Reset: asynchronous, active low; clears the sequencer and the output valid.
module epoch_seconds_to_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [11:0] year
);
    import esc_pkg::*;

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_YEAR   = 3'd2;
    localparam logic [2:0] ST_MONTH  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  pass_reg, pass_next;
    logic        phase_reg, phase_next;
    logic [31:0] quot_reg, quot_next;
    logic [63:0] prod_reg, prod_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hr_reg, hr_next;
    logic [15:0] days_reg, days_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;

    logic        out_valid_reg, out_valid_next;
    logic [5:0]  out_sec_reg, out_sec_next;
    logic [5:0]  out_min_reg, out_min_next;
    logic [4:0]  out_hr_reg, out_hr_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [3:0]  out_mon_reg, out_mon_next;
    logic [11:0] out_year_reg, out_year_next;

    // Shared compare-and-subtract unit
    logic [15:0] alu_a;
    logic [15:0] alu_b;
    logic [16:0] alu_diff;
    logic        alu_ge;

    // Shared reciprocal multiplier for the constant divisions
    logic [31:0] recip;
    logic [63:0] mul_out;
    logic [31:0] div_quot;
    logic [5:0]  divisor;
    logic [11:0] div_back;
    logic [5:0]  div_rem;
    logic        leap;

    assign recip    = (pass_reg == PASS_HOUR) ? RECIP_THREE : RECIP_SIXTY;
    assign divisor  = (pass_reg == PASS_HOUR) ? HOUR_PER_DAY : SEC_PER_MIN;
    assign mul_out  = quot_reg * recip;
    assign leap     = is_leap(year_reg);

    // Quotient from the registered product; the remainder is below 64, so only
    // the low six bits of the dividend and of quotient times divisor matter.
    assign div_quot = (pass_reg == PASS_HOUR) ? {4'd0, prod_reg[63:36]}
                                              : {5'd0, prod_reg[63:37]};
    assign div_back = div_quot[5:0] * divisor;
    assign div_rem  = quot_reg[5:0] - div_back[5:0];

    // Operand selection for the shared unit
    always_comb
    begin
        case (state_reg)
            ST_YEAR:
            begin
                alu_a = days_reg;
                alu_b = leap ? DAYS_LEAP : DAYS_COMMON;
            end
            ST_MONTH:
            begin
                alu_a = days_reg;
                alu_b = month_days(mon_reg, leap);
            end
            default:
            begin
                alu_a = days_reg;
                alu_b = 16'd0;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = ~alu_diff[16];

    // Sequencer and datapath next-state logic
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        phase_next     = phase_reg;
        quot_next      = quot_reg;
        prod_next      = prod_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hr_next        = hr_reg;
        days_next      = days_reg;
        year_next      = year_reg;
        mon_next       = mon_reg;
        out_valid_next = out_valid_reg;
        out_sec_next   = out_sec_reg;
        out_min_next   = out_min_reg;
        out_hr_next    = out_hr_reg;
        out_day_next   = out_day_reg;
        out_mon_next   = out_mon_reg;
        out_year_next  = out_year_reg;

        // The receiver takes the held result.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    quot_next  = epoch_seconds;
                    pass_next  = PASS_SEC;
                    phase_next = 1'b0;
                    state_next = ST_DIV;
                end
            end

            // Each division first registers the product, then the quotient replaces the
            // dividend and the remainder is kept.
            ST_DIV:
            begin
                if (!phase_reg)
                begin
                    prod_next  = mul_out;
                    phase_next = 1'b1;
                end
                else
                begin
                    quot_next  = div_quot;
                    phase_next = 1'b0;
                    case (pass_reg)
                        PASS_SEC:
                        begin
                            sec_next  = div_rem;
                            pass_next = PASS_MIN;
                        end
                        PASS_MIN:
                        begin
                            min_next  = div_rem;
                            pass_next = PASS_HOUR;
                        end
                        PASS_HOUR:
                        begin
                            hr_next    = div_rem[4:0];
                            days_next  = div_quot[15:0];
                            year_next  = EPOCH_YEAR;
                            state_next = ST_YEAR;
                        end
                        default:
                        begin
                            pass_next = PASS_SEC;
                        end
                    endcase
                end
            end

            // Remove one whole year per cycle.
            ST_YEAR:
            begin
                if (alu_ge)
                begin
                    days_next = alu_diff[15:0];
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    mon_next   = 4'd0;
                    state_next = ST_MONTH;
                end
            end

            // Remove one whole month per cycle, stopping at December.
            ST_MONTH:
            begin
                if (alu_ge && (mon_reg != LAST_MONTH))
                begin
                    days_next = alu_diff[15:0];
                    mon_next  = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            // Load the output register once it is free.
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sec_next   = sec_reg;
                    out_min_next   = min_reg;
                    out_hr_next    = hr_reg;
                    out_day_next   = days_reg[4:0] + 5'd1;
                    out_mon_next   = mon_reg + 4'd1;
                    out_year_next  = year_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_SEC;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        prod_reg     <= prod_next;
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hr_reg       <= hr_next;
        days_reg     <= days_next;
        year_reg     <= year_next;
        mon_reg      <= mon_next;
        out_sec_reg  <= out_sec_next;
        out_min_reg  <= out_min_next;
        out_hr_reg   <= out_hr_next;
        out_day_reg  <= out_day_next;
        out_mon_reg  <= out_mon_next;
        out_year_reg <= out_year_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign second    = out_sec_reg;
    assign minute    = out_min_reg;
    assign hour      = out_hr_reg;
    assign day       = out_day_reg;
    assign month     = out_mon_reg;
    assign year      = out_year_reg;

endmodule
